// File: src/uvs_pkg.sv
// ============================================================================
// uvs_pkg
// Shared types and constants of the UV sphere vertex generator.
// ============================================================================
package uvs_pkg;

    localparam int LAT_W    = 8;
    localparam int LON_W    = 9;
    localparam int SEG_W    = 8;
    localparam int RAD_W    = 16;
    localparam int POS_W    = 17;
    localparam int TEX_W    = 17;
    localparam int CORNER_W = 16;
    localparam int DIV_W    = 9;     // divisor 2S
    localparam int REM_W    = 10;    // partial remainder of the divider cells
    localparam int LANES    = 4;     // theta, phi, u, v quotients

    localparam int HORNER_STEPS = 6;
    localparam int HORNER_LAT   = 3;
    localparam int SINCOS_LAT   = 2 + HORNER_STEPS * HORNER_LAT + 1;

    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Taylor divisors, innermost term last
    localparam int SIN_DIV [HORNER_STEPS] = '{6, 20, 42, 72, 110, 156};
    localparam int COS_DIV [HORNER_STEPS] = '{2, 12, 30, 56, 90, 132};

    typedef enum logic [1:0] {
        REG_SEGMENTS = 2'd0,
        REG_RADIUS   = 2'd1,
        REG_MAPPING  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [30:0] sin_mag;
        logic        sin_neg;
        logic [30:0] cos_mag;
        logic        cos_neg;
    } trig_t;

    typedef struct packed {
        logic                in_range;
        logic                quad_valid;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
    } side_t;

    typedef struct packed {
        logic [TEX_W-1:0] tex_u;
        logic [TEX_W-1:0] tex_v;
    } tex_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos_x;
        logic [POS_W-1:0]    pos_y;
        logic [POS_W-1:0]    pos_z;
        logic [TEX_W-1:0]    tex_u;
        logic [TEX_W-1:0]    tex_v;
        logic                tex_valid;
        logic [CORNER_W-1:0] corner_a;
        logic [CORNER_W-1:0] corner_b;
        logic [CORNER_W-1:0] corner_c;
        logic [CORNER_W-1:0] corner_d;
        logic                quad_valid;
        logic                in_range;
    } result_t;

endpackage

// File: src/uvs_div_cell.sv
// ============================================================================
// uvs_div_cell
// One restoring division step for all lanes; a row of these forms the divider.
// ============================================================================
module uvs_div_cell #(
    parameter int QD = 18
) (
    input  logic                                              aclk,
    input  logic                                              en,
    input  logic [uvs_pkg::DIV_W-1:0]                         divisor,
    input  logic [uvs_pkg::LANES-1:0][uvs_pkg::REM_W-1:0]     rem_in,
    input  logic [uvs_pkg::LANES-1:0][QD-1:0]                 nq_in,
    output logic [uvs_pkg::LANES-1:0][uvs_pkg::REM_W-1:0]     rem_out,
    output logic [uvs_pkg::LANES-1:0][QD-1:0]                 nq_out
);

    logic [uvs_pkg::LANES-1:0][uvs_pkg::REM_W-1:0] rem_next;
    logic [uvs_pkg::LANES-1:0][QD-1:0]             nq_next;
    logic [uvs_pkg::LANES-1:0][uvs_pkg::REM_W-1:0] rem_reg;
    logic [uvs_pkg::LANES-1:0][QD-1:0]             nq_reg;

    // nq holds the numerator bits still to come (top) and quotient bits (bottom)
    always_comb begin
        logic [uvs_pkg::REM_W-1:0] trial;
        logic                      ge;
        for (int i = 0; i < uvs_pkg::LANES; i++) begin
            trial       = {rem_in[i][uvs_pkg::REM_W-2:0], nq_in[i][QD-1]};
            ge          = (trial >= uvs_pkg::REM_W'(divisor));
            rem_next[i] = ge ? (trial - uvs_pkg::REM_W'(divisor)) : trial;
            nq_next[i]  = {nq_in[i][QD-2:0], ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            nq_reg  <= nq_next;
        end
    end

    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule

// File: src/uvs_horner_cell.sv
// ============================================================================
// uvs_horner_cell
// One Horner step t' = 1 - floor(floor(z2*t/2^30)/K) in Q30, three stages.
// ============================================================================
module uvs_horner_cell #(
    parameter int K = 6
) (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] z2_in,
    input  logic [31:0] t_in,
    output logic [31:0] z2_out,
    output logic [31:0] t_out
);

    localparam logic [63:0] RECIP = (64'd1 << 32) / K;

    logic [31:0] v1_reg, z2a_reg;
    logic [31:0] v2_reg, q0_reg, z2b_reg;
    logic [31:0] t_reg, z2c_reg;
    logic [31:0] v1_next, q0_next, t_next;

    // stage 1: product with the running term (t is positive here)
    always_comb begin
        logic [62:0] p;
        p       = 63'(z2_in) * 63'(t_in[30:0]);
        v1_next = p[61:30];
    end

    // stage 2: reciprocal estimate, low by at most one
    always_comb begin
        logic [63:0] pm;
        pm      = 64'(v1_reg) * 64'(RECIP[31:0]);
        q0_next = pm[63:32];
    end

    // stage 3: one correction step, then subtract from one
    always_comb begin
        logic [39:0] qk;
        logic [31:0] rem;
        logic [31:0] q;
        qk     = 40'(q0_reg) * 40'(K);
        rem    = v2_reg - qk[31:0];
        q      = q0_reg + 32'(rem >= 32'(K));
        t_next = uvs_pkg::Q30_ONE - q;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v1_reg  <= v1_next;
            z2a_reg <= z2_in;
            v2_reg  <= v1_reg;
            q0_reg  <= q0_next;
            z2b_reg <= z2a_reg;
            t_reg   <= t_next;
            z2c_reg <= z2b_reg;
        end
    end

    assign z2_out = z2c_reg;
    assign t_out  = t_reg;

endmodule

// File: src/uvs_sincos.sv
// ============================================================================
// uvs_sincos
// Sine and cosine of an angle in turns: quarter-turn reduction, two rows of
// Horner cells, clamping and quadrant fold.
// ============================================================================
module uvs_sincos #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [ANGLE_BITS-1:0] angle,
    output uvs_pkg::trig_t        trig
);

    localparam int CHAIN = uvs_pkg::HORNER_STEPS * uvs_pkg::HORNER_LAT;

    logic [30:0] z1_reg, z2z_reg;
    logic [1:0]  q1_reg, q2_reg;
    logic [31:0] z2_reg;
    logic [30:0] z1_next;
    logic [31:0] z2_next;
    logic [30:0] zd_reg [CHAIN];
    logic [1:0]  qd_reg [CHAIN];

    logic [31:0] s_z2 [uvs_pkg::HORNER_STEPS+1];
    logic [31:0] s_t  [uvs_pkg::HORNER_STEPS+1];
    logic [31:0] c_z2 [uvs_pkg::HORNER_STEPS+1];
    logic [31:0] c_t  [uvs_pkg::HORNER_STEPS+1];

    uvs_pkg::trig_t trig_reg, trig_next;

    always_comb begin
        logic [29:0] x;
        logic [60:0] p1;
        logic [61:0] p2;
        x       = 30'(angle[ANGLE_BITS-3:0]) << (32 - ANGLE_BITS);
        p1      = 61'(x) * 61'(uvs_pkg::HALF_PI_Q30);
        z1_next = p1[60:30];
        p2      = 62'(z1_reg) * 62'(z1_reg);
        z2_next = p2[61:30];
    end

    assign s_z2[0] = z2_reg;
    assign c_z2[0] = z2_reg;
    assign s_t[0]  = uvs_pkg::Q30_ONE;
    assign c_t[0]  = uvs_pkg::Q30_ONE;

    for (genvar j = 0; j < uvs_pkg::HORNER_STEPS; j++) begin : g_step
        uvs_horner_cell #(
            .K (uvs_pkg::SIN_DIV[uvs_pkg::HORNER_STEPS-1-j])
        ) u_sin (
            .aclk   (aclk),
            .en     (en),
            .z2_in  (s_z2[j]),
            .t_in   (s_t[j]),
            .z2_out (s_z2[j+1]),
            .t_out  (s_t[j+1])
        );
        uvs_horner_cell #(
            .K (uvs_pkg::COS_DIV[uvs_pkg::HORNER_STEPS-1-j])
        ) u_cos (
            .aclk   (aclk),
            .en     (en),
            .z2_in  (c_z2[j]),
            .t_in   (c_t[j]),
            .z2_out (c_z2[j+1]),
            .t_out  (c_t[j+1])
        );
    end

    // clamp to [0, 1] and fold the quadrant; a zero never counts as negative
    always_comb begin
        logic signed [63:0] sp;
        logic signed [63:0] sv;
        logic signed [31:0] tc;
        logic [30:0]        s_m;
        logic [30:0]        c_m;
        sp = $signed({1'b0, zd_reg[CHAIN-1]}) * $signed(s_t[uvs_pkg::HORNER_STEPS]);
        sv = sp >>> 30;
        if (sv < 0) begin
            s_m = '0;
        end else if (sv > 64'sd1073741824) begin
            s_m = uvs_pkg::Q30_ONE[30:0];
        end else begin
            s_m = sv[30:0];
        end
        tc = $signed(c_t[uvs_pkg::HORNER_STEPS]);
        if (tc < 0) begin
            c_m = '0;
        end else if (tc > $signed(uvs_pkg::Q30_ONE)) begin
            c_m = uvs_pkg::Q30_ONE[30:0];
        end else begin
            c_m = tc[30:0];
        end
        case (qd_reg[CHAIN-1])
            2'd0: begin
                trig_next = '{sin_mag: s_m, sin_neg: 1'b0, cos_mag: c_m, cos_neg: 1'b0};
            end
            2'd1: begin
                trig_next = '{sin_mag: c_m, sin_neg: 1'b0, cos_mag: s_m,
                              cos_neg: (s_m != '0)};
            end
            2'd2: begin
                trig_next = '{sin_mag: s_m, sin_neg: (s_m != '0), cos_mag: c_m,
                              cos_neg: (c_m != '0)};
            end
            default: begin
                trig_next = '{sin_mag: c_m, sin_neg: (c_m != '0), cos_mag: s_m,
                              cos_neg: 1'b0};
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z1_reg    <= z1_next;
            q1_reg    <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
            z2_reg    <= z2_next;
            z2z_reg   <= z1_reg;
            q2_reg    <= q1_reg;
            zd_reg[0] <= z2z_reg;
            qd_reg[0] <= q2_reg;
            for (int k = 1; k < CHAIN; k++) begin
                zd_reg[k] <= zd_reg[k-1];
                qd_reg[k] <= qd_reg[k-1];
            end
            trig_reg  <= trig_next;
        end
    end

    assign trig = trig_reg;

endmodule

// File: src/uv_sphere_vertex_generator.sv
// ============================================================================
// uv_sphere_vertex_generator
// Vertex, texture coordinate and quad corner generator for a UV sphere grid.
// ============================================================================
// One grid point (lat_index, lon_index) in, one result item out, one item per
// clock sustained while the output queue is not full. The item flows through
// a fixed pipeline: an input stage, a row of QD = max(ANGLE_BITS+1, 18)
// restoring divider cells (one quotient bit each, all four quotients theta,
// phi, u, v side by side), the sine/cosine unit (SINCOS_LAT = 21 stages, two
// rows of six three-stage Horner cells), and a product stage. A two-item output
// queue lets the pipeline keep taking items while a finished result waits; the
// pipeline halts only when that queue is full. Configuration writes are taken
// at any time (cfg_ready is tied high) and must only be issued while no item
// is in flight.
// ============================================================================
module uv_sphere_vertex_generator #(
    parameter int MAX_SEGMENTS = 128,
    parameter int ANGLE_BITS   = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_data,
    // input items
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,    // lat_index[7:0], lon_index[16:8], zero pad
    // result items
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [151:0] m_tdata,    // pos_x, pos_y, pos_z, tex_u, tex_v,
                                     // corner_a, corner_b, corner_c, corner_d,
                                     // zero pad
    output logic [2:0]   m_tuser     // tex_valid, quad_valid, in_range
);

    localparam int SHW     = (ANGLE_BITS > 17) ? ANGLE_BITS : 17;
    localparam int QD      = (ANGLE_BITS + 1 > 18) ? ANGLE_BITS + 1 : 18;
    localparam int NW      = 10 + SHW;
    localparam int L       = QD + uvs_pkg::SINCOS_LAT + 1;
    localparam int SEG_CAP = (MAX_SEGMENTS > 255) ? 255 : MAX_SEGMENTS;

    // ---------------- configuration ----------------
    logic [uvs_pkg::SEG_W-1:0] seg_reg;
    logic [uvs_pkg::RAD_W-1:0] radius_reg;
    logic                      map_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg    <= 8'd16;
            radius_reg <= 16'd256;
            map_reg    <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                uvs_pkg::REG_SEGMENTS: seg_reg    <= cfg_data[7:0];
                uvs_pkg::REG_RADIUS:   radius_reg <= cfg_data;
                uvs_pkg::REG_MAPPING:  map_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective band count; the user must keep it stable while items are in flight, the block has no guard for this
    logic [uvs_pkg::SEG_W-1:0] seg_eff;
    logic [uvs_pkg::DIV_W-1:0] two_s;

    assign seg_eff = (seg_reg == '0) ? 8'd1 :
                     ((seg_reg > SEG_CAP[7:0]) ? SEG_CAP[7:0] : seg_reg);
    assign two_s   = {seg_eff, 1'b0};

    // ---------------- flow control ----------------
    logic [1:0]      cnt_reg, cnt_next;
    logic            en;
    logic [L:0]      vld_reg;
    logic            push, pop;

    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    // ---------------- input stage ----------------
    logic [uvs_pkg::LAT_W-1:0] lat_reg;
    logic [uvs_pkg::LON_W-1:0] lon_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            lat_reg <= s_tdata[7:0];
            lon_reg <= s_tdata[16:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[L-1:0], s_tvalid};
        end
    end

    // ---------------- grid bookkeeping ----------------
    uvs_pkg::side_t side_next;
    uvs_pkg::side_t side_reg [L];

    always_comb begin
        logic [16:0] base;
        logic [8:0]  row;
        logic        inr, quad;
        row  = two_s + 9'd1;
        base = 17'(lat_reg) * 17'(row) + 17'(lon_reg);
        inr  = (lat_reg <= seg_eff) && (10'(lon_reg) <= 10'(two_s));
        quad = (lat_reg < seg_eff) && (10'(lon_reg) < 10'(two_s));
        side_next.in_range   = inr;
        side_next.quad_valid = quad;
        side_next.corner_a   = quad ? base[15:0] : '0;
        side_next.corner_b   = quad ? (base[15:0] + 16'(row)) : '0;
        side_next.corner_c   = quad ? (base[15:0] + 16'(row) + 16'd1) : '0;
        side_next.corner_d   = quad ? (base[15:0] + 16'd1) : '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_next;
            for (int k = 1; k < L; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // ---------------- divider row ----------------
    // numerators (idx << shift) + S over 2S; top bits start the remainder
    logic [uvs_pkg::LANES-1:0][NW-1:0]            num;
    logic [uvs_pkg::LANES-1:0][uvs_pkg::REM_W-1:0] rem_c [QD+1];
    logic [uvs_pkg::LANES-1:0][QD-1:0]            nq_c  [QD+1];

    always_comb begin
        num[0] = (NW'(lat_reg) << ANGLE_BITS) + NW'(seg_eff);
        num[1] = (NW'(lon_reg) << ANGLE_BITS) + NW'(seg_eff);
        num[2] = (NW'(lon_reg) << 16) + NW'(seg_eff);
        num[3] = (NW'(lat_reg) << 17) + NW'(seg_eff);
        for (int i = 0; i < uvs_pkg::LANES; i++) begin
            rem_c[0][i] = uvs_pkg::REM_W'(num[i][NW-1:QD]);
            nq_c[0][i]  = num[i][QD-1:0];
        end
    end

    for (genvar k = 0; k < QD; k++) begin : g_div
        uvs_div_cell #(
            .QD (QD)
        ) u_cell (
            .aclk    (aclk),
            .en      (en),
            .divisor (two_s),
            .rem_in  (rem_c[k]),
            .nq_in   (nq_c[k]),
            .rem_out (rem_c[k+1]),
            .nq_out  (nq_c[k+1])
        );
    end

    // ---------------- texture coordinates wait for the trig unit ----------------
    uvs_pkg::tex_t tex_reg [uvs_pkg::SINCOS_LAT+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            tex_reg[0] <= '{tex_u: nq_c[QD][2][16:0], tex_v: nq_c[QD][3][16:0]};
            for (int k = 1; k <= uvs_pkg::SINCOS_LAT; k++) begin
                tex_reg[k] <= tex_reg[k-1];
            end
        end
    end

    // ---------------- sine and cosine ----------------
    uvs_pkg::trig_t trig_th, trig_ph;

    uvs_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_theta (
        .aclk  (aclk),
        .en    (en),
        .angle (nq_c[QD][0][ANGLE_BITS-1:0]),
        .trig  (trig_th)
    );

    uvs_sincos #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_phi (
        .aclk  (aclk),
        .en    (en),
        .angle (nq_c[QD][1][ANGLE_BITS-1:0]),
        .trig  (trig_ph)
    );

    // ---------------- direction products ----------------
    logic [30:0] mx_reg, my_reg, mz_reg;
    logic        nx_reg, ny_reg, nz_reg;
    logic [30:0] mx_next, my_next;

    always_comb begin
        logic [61:0] px, py;
        px      = 62'(trig_th.sin_mag) * 62'(trig_ph.cos_mag) + 62'h2000_0000;
        py      = 62'(trig_th.sin_mag) * 62'(trig_ph.sin_mag) + 62'h2000_0000;
        mx_next = px[60:30];
        my_next = py[60:30];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            mz_reg <= trig_th.cos_mag;
            nx_reg <= trig_th.sin_neg ^ trig_ph.cos_neg;
            ny_reg <= trig_th.sin_neg ^ trig_ph.sin_neg;
            nz_reg <= trig_th.cos_neg;
        end
    end

    // ---------------- radius scaling and result assembly ----------------
    function automatic logic [uvs_pkg::POS_W-1:0] scale_pos(
        input logic [uvs_pkg::RAD_W-1:0] radius,
        input logic [30:0]               mag,
        input logic                      neg
    );
        logic [47:0]               p;
        logic [uvs_pkg::POS_W-1:0] v;
        p = 48'(radius) * 48'(mag) + 48'h2000_0000;
        v = p[46:30];
        return neg ? (uvs_pkg::POS_W'(0) - v) : v;
    endfunction

    uvs_pkg::result_t res;
    uvs_pkg::side_t   sd;
    uvs_pkg::tex_t    tx;

    assign sd = side_reg[L-1];
    assign tx = tex_reg[uvs_pkg::SINCOS_LAT];

    always_comb begin
        logic tv;
        tv             = map_reg && sd.in_range;
        res.pos_x      = sd.in_range ? scale_pos(radius_reg, mx_reg, nx_reg) : '0;
        res.pos_y      = sd.in_range ? scale_pos(radius_reg, my_reg, ny_reg) : '0;
        res.pos_z      = sd.in_range ? scale_pos(radius_reg, mz_reg, nz_reg) : '0;
        res.tex_u      = tv ? tx.tex_u : '0;
        res.tex_v      = tv ? tx.tex_v : '0;
        res.tex_valid  = tv;
        res.corner_a   = sd.corner_a;
        res.corner_b   = sd.corner_b;
        res.corner_c   = sd.corner_c;
        res.corner_d   = sd.corner_d;
        res.quad_valid = sd.quad_valid;
        res.in_range   = sd.in_range;
    end

    // ---------------- two-item output queue ----------------
    uvs_pkg::result_t f0_reg, f1_reg;

    assign push = en && vld_reg[L];
    assign pop  = m_tvalid && m_tready;

    always_comb begin
        cnt_next = cnt_reg;
        case (cnt_reg)
            2'd0:    cnt_next = push ? 2'd1 : 2'd0;
            2'd1:    cnt_next = (push && !pop) ? 2'd2 : ((pop && !push) ? 2'd0 : 2'd1);
            2'd2:    cnt_next = pop ? 2'd1 : 2'd2;
            default: cnt_next = 2'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_reg == 2'd2 && pop) begin
            f0_reg <= f1_reg;
        end else if ((cnt_reg == 2'd0 && push) || (cnt_reg == 2'd1 && pop && push)) begin
            f0_reg <= res;
        end
        if (cnt_reg == 2'd1 && push && !pop) begin
            f1_reg <= res;
        end
    end

    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {3'b000, f0_reg.corner_d, f0_reg.corner_c, f0_reg.corner_b,
                       f0_reg.corner_a, f0_reg.tex_v, f0_reg.tex_u, f0_reg.pos_z,
                       f0_reg.pos_y, f0_reg.pos_x};
    assign m_tuser  = {f0_reg.in_range, f0_reg.quad_valid, f0_reg.tex_valid};

    // ---------------- assertions ----------------
    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[2]) |-> (m_tdata == '0 && m_tuser == '0))
        else $error("out-of-range item carries nonzero fields");

    a_quad_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> m_tuser[2])
        else $error("quad flagged outside the grid");

    a_tex_needs_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2] && map_reg))
        else $error("texture flag without mapping or range");

    a_full_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd2) |-> (!s_tready && !push))
        else $error("pipeline moved while queue full");

    a_queue_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 && !push) |=> (cnt_reg == 2'd0))
        else $error("queue filled without a push");

endmodule
